### rtl/sumd_pkg.sv
// shared types, constants and the crc step for the sumd frame encoder
`timescale 1ns / 1ps

package sumd_pkg;

    localparam int MAX_CHANNELS_DEF = 16;

    localparam logic [7:0]  HDR_BYTE        = 8'hA8;
    localparam logic [7:0]  STATUS_OK       = 8'h01;
    localparam logic [7:0]  STATUS_FAILSAFE = 8'h81;
    localparam logic [15:0] CRC_POLY        = 16'h1021;
    localparam logic [15:0] CRC_INIT        = 16'h0000;
    localparam logic [4:0]  NUM_CH_RESET    = 5'd8;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_STOP   = 2'd2,
        CMD_TICK   = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [3:0]  channel_index;
        logic [15:0] channel_value;
        logic        failsafe;
    } t_sumd_in;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_sumd_out;

    // one byte of crc-16 0x1021, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### rtl/sumd_chan_store.sv
// channel value memory with per-entry valid bits, registered read
`timescale 1ns / 1ps

module sumd_chan_store #(
    parameter int DEPTH = sumd_pkg::MAX_CHANNELS_DEF,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [15:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [15:0]   o_rdata
);
    import sumd_pkg::*;

    logic [15:0]      r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [15:0]      r_rdata;
    logic             r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_valid <= r_valid[i_raddr];
            end
        end
    end

    // never-written entries read as zero
    assign o_rdata = r_rd_valid ? r_rdata : 16'h0000;

endmodule

### rtl/sumd_frame_store.sv
// latched frame byte memory, one write port and one registered read port
`timescale 1ns / 1ps

module sumd_frame_store #(
    parameter int DEPTH = 2 * sumd_pkg::MAX_CHANNELS_DEF + 5,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    import sumd_pkg::*;

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/sumd_frame_encoder.sv
// sumd frame encoder top level: command sequencer, frame builder and byte output queue
`timescale 1ns / 1ps

// Commands are taken one at a time, only while the sequencer is idle. A channel write
// or a stop leaves the sequencer idle. An update builds a frame of 2*n+5 bytes, n being
// the clamped channel count: the builder writes one frame byte per cycle into the frame
// memory, reading each channel from the channel memory ahead of its high byte and
// folding every header and channel byte into the crc. A tick while running reads the
// 2*n+5 frame bytes one per cycle as long as the output is taken, then returns to idle;
// bytes go through a two-entry output queue, so the next command can be accepted while
// the last bytes still wait. A tick while stopped sends nothing. The count register is
// sampled at update, so the latched frame keeps its length until the next update.
module sumd_frame_encoder #(
    parameter int MAX_CHANNELS = sumd_pkg::MAX_CHANNELS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sumd_pkg::t_sumd_in  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sumd_pkg::t_sumd_out o_out,
    input  logic                i_cfg_we,
    input  logic [4:0]          i_cfg_num_channels
);
    import sumd_pkg::*;

    localparam int FRAME_MAX = 2 * MAX_CHANNELS + 5;
    localparam int CH_AW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CI_W      = $clog2(MAX_CHANNELS + 1);
    localparam int FA_W      = $clog2(FRAME_MAX);
    localparam int FP_W      = $clog2(FRAME_MAX + 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_HDR  = 7'b0000010,
        S_CHH  = 7'b0000100,
        S_CHL  = 7'b0001000,
        S_CRCH = 7'b0010000,
        S_CRCL = 7'b0100000,
        S_TX   = 7'b1000000
    } t_state;

    t_state          r_state, n_state;
    logic            r_fs, n_fs;
    logic [CI_W-1:0] r_n, n_n;
    logic [CI_W-1:0] r_ch, n_ch;
    logic [FP_W-1:0] r_wpos, n_wpos;
    logic [FP_W-1:0] r_len, n_len;
    logic [FP_W-1:0] r_rpos, n_rpos;
    logic [15:0]     r_crc, n_crc;
    logic            r_running, n_running;
    logic            r_inflight, n_inflight;
    logic            r_inf_last, n_inf_last;
    logic [4:0]      r_num_ch;
    logic [1:0]      r_cnt;
    t_sumd_out       r_q [2];

    logic            in_xfer;
    logic            out_pop;
    logic [CI_W-1:0] eff_n;
    logic [CI_W-1:0] ch_next;
    logic [CI_W-1:0] ch_rsel;
    logic            ch_we;
    logic            ch_re;
    logic [15:0]     ch_rdata;
    logic [15:0]     ch_shifted;
    logic            fr_we;
    logic [7:0]      fr_wdata;
    logic            fr_re;
    logic [7:0]      fr_rdata;
    logic            can_issue;
    logic [1:0]      push_idx;
    t_sumd_out       push_item;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out       = r_q[0];
    assign out_pop     = o_out_valid && i_out_ready;

    // clamp the configured count to 1..MAX_CHANNELS
    always_comb begin
        if (r_num_ch == 5'd0) begin
            eff_n = CI_W'(1);
        end else if (int'(r_num_ch) > MAX_CHANNELS) begin
            eff_n = CI_W'(MAX_CHANNELS);
        end else begin
            eff_n = CI_W'(r_num_ch);
        end
    end

    assign ch_we      = in_xfer && (i_in.cmd == CMD_WRITE) &&
                        (int'(i_in.channel_index) < MAX_CHANNELS);
    assign ch_next    = r_ch + CI_W'(1);
    assign ch_rsel    = (r_state == S_CHL) ? ch_next : r_ch;
    assign ch_shifted = {ch_rdata[12:0], 3'b000};

    // read slot is free unless queue plus in-flight read already fill both entries and no byte leaves
    assign can_issue = (r_cnt + {1'b0, r_inflight} != 2'd2) || out_pop;

    always_comb begin
        n_state    = r_state;
        n_fs       = r_fs;
        n_n        = r_n;
        n_ch       = r_ch;
        n_wpos     = r_wpos;
        n_len      = r_len;
        n_rpos     = r_rpos;
        n_crc      = r_crc;
        n_running  = r_running;
        n_inflight = 1'b0;
        n_inf_last = r_inf_last;
        ch_re      = 1'b0;
        fr_we      = 1'b0;
        fr_wdata   = 8'h00;
        fr_re      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    unique case (i_in.cmd)
                        CMD_WRITE: begin
                        end
                        CMD_UPDATE: begin
                            n_fs    = i_in.failsafe;
                            n_n     = eff_n;
                            n_ch    = '0;
                            n_wpos  = '0;
                            n_crc   = CRC_INIT;
                            n_state = S_HDR;
                        end
                        CMD_STOP: begin
                            n_running = 1'b0;
                        end
                        CMD_TICK: begin
                            if (r_running) begin
                                n_rpos  = '0;
                                n_state = S_TX;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_HDR: begin
                fr_we = 1'b1;
                priority if (r_wpos == FP_W'(0)) begin
                    fr_wdata = HDR_BYTE;
                end else if (r_wpos == FP_W'(1)) begin
                    fr_wdata = r_fs ? STATUS_FAILSAFE : STATUS_OK;
                end else begin
                    fr_wdata = 8'(r_n);
                end
                n_crc  = crc_byte(r_crc, fr_wdata);
                n_wpos = r_wpos + FP_W'(1);
                if (r_wpos == FP_W'(2)) begin
                    // fetch channel 0 so it lands for the first high byte
                    ch_re   = 1'b1;
                    n_state = S_CHH;
                end
            end
            S_CHH: begin
                fr_we    = 1'b1;
                fr_wdata = ch_shifted[15:8];
                n_crc    = crc_byte(r_crc, fr_wdata);
                n_wpos   = r_wpos + FP_W'(1);
                n_state  = S_CHL;
            end
            S_CHL: begin
                fr_we    = 1'b1;
                fr_wdata = ch_shifted[7:0];
                n_crc    = crc_byte(r_crc, fr_wdata);
                n_wpos   = r_wpos + FP_W'(1);
                n_ch     = ch_next;
                if (ch_next < r_n) begin
                    ch_re   = 1'b1;
                    n_state = S_CHH;
                end else begin
                    n_state = S_CRCH;
                end
            end
            S_CRCH: begin
                fr_we    = 1'b1;
                fr_wdata = r_crc[15:8];
                n_wpos   = r_wpos + FP_W'(1);
                n_state  = S_CRCL;
            end
            S_CRCL: begin
                fr_we     = 1'b1;
                fr_wdata  = r_crc[7:0];
                n_len     = r_wpos + FP_W'(1);
                n_running = 1'b1;
                n_state   = S_IDLE;
            end
            S_TX: begin
                if (r_rpos == r_len) begin
                    n_state = S_IDLE;
                end else if (can_issue) begin
                    fr_re      = 1'b1;
                    n_inflight = 1'b1;
                    n_inf_last = (r_rpos == r_len - FP_W'(1));
                    n_rpos     = r_rpos + FP_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_running  <= 1'b0;
            r_len      <= '0;
            r_inflight <= 1'b0;
            r_num_ch   <= NUM_CH_RESET;
        end else begin
            r_state    <= n_state;
            r_running  <= n_running;
            r_len      <= n_len;
            r_inflight <= n_inflight;
            if (i_cfg_we) begin
                r_num_ch <= i_cfg_num_channels;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fs       <= n_fs;
        r_n        <= n_n;
        r_ch       <= n_ch;
        r_wpos     <= n_wpos;
        r_rpos     <= n_rpos;
        r_crc      <= n_crc;
        r_inf_last <= n_inf_last;
    end

    // output queue: head at entry 0, read data lands behind whatever stays
    assign push_idx             = r_cnt - {1'b0, out_pop};
    assign push_item.frame_byte = fr_rdata;
    assign push_item.last_byte  = r_inf_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, r_inflight} - {1'b0, out_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_inflight && (push_idx == 2'd0)) begin
            r_q[0] <= push_item;
        end else if (out_pop) begin
            r_q[0] <= r_q[1];
        end
        if (r_inflight && (push_idx == 2'd1)) begin
            r_q[1] <= push_item;
        end
    end

    sumd_chan_store #(
        .DEPTH (MAX_CHANNELS),
        .AW    (CH_AW)
    ) u_chan_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (ch_we),
        .i_waddr (CH_AW'(i_in.channel_index)),
        .i_wdata (i_in.channel_value),
        .i_re    (ch_re),
        .i_raddr (ch_rsel[CH_AW-1:0]),
        .o_rdata (ch_rdata)
    );

    sumd_frame_store #(
        .DEPTH (FRAME_MAX),
        .AW    (FA_W)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_we    (fr_we),
        .i_waddr (r_wpos[FA_W-1:0]),
        .i_wdata (fr_wdata),
        .i_re    (fr_re),
        .i_raddr (r_rpos[FA_W-1:0]),
        .o_rdata (fr_rdata)
    );

`ifndef SYNTHESIS
    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_cnt} + {2'b00, r_inflight}) <= 3'd2)
        else $error("output queue overfilled");

    a_frame_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CRCL) |=> r_running && (int'(r_len) == 2 * int'(r_n) + 5))
        else $error("latched frame length does not match channel count");

    a_chan_read_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ch_re |-> (ch_rsel < r_n))
        else $error("channel read beyond latched count");

    a_frame_read_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fr_re |-> r_running && (r_rpos < r_len))
        else $error("frame read beyond latched length");
`endif

endmodule

### sim/tb_sumd_frame_encoder.sv
// testbench for the sumd frame encoder: frame prediction, byte checking and command traffic
`timescale 1ns / 1ps

module tb_sumd_frame_encoder;
    import sumd_pkg::*;

    localparam int MAX_CH       = MAX_CHANNELS_DEF;
    localparam int FRAME_BYTES  = 2 * MAX_CH + 5;
    localparam int DRAIN_CYCLES = FRAME_BYTES + 16;
    localparam int RANDOM_ITEMS = 345;
    localparam int CYCLE_LIMIT  = 1000000;

    localparam logic [1:0] RX_FULL    = 2'd0;
    localparam logic [1:0] RX_RANDOM  = 2'd1;
    localparam logic [1:0] RX_PATTERN = 2'd2;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    t_sumd_in    in_data   = '0;
    logic        out_ready = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [4:0]  cfg_count = NUM_CH_RESET;
    logic        in_ready;
    logic        out_valid;
    t_sumd_out   out_data;

    // predictor state
    logic [15:0] chan_vals [MAX_CH];
    logic [7:0]  frame_buf [FRAME_BYTES];
    int          frame_len = 0;
    bit          running = 1'b0;
    logic [4:0]  num_ch_reg = NUM_CH_RESET;
    t_sumd_out   exp_bytes [$];

    int          errors = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          ready_hold = 0;
    logic [1:0]  rx_mode = RX_FULL;

    sumd_frame_encoder dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_in               (in_data),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_out              (out_data),
        .i_cfg_we           (cfg_we),
        .i_cfg_num_channels (cfg_count)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        foreach (chan_vals[i]) chan_vals[i] = '0;
        foreach (frame_buf[i]) frame_buf[i] = '0;
    end

    // crc-16 0x1021 folded one data bit at a time
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
        logic fb;
        for (int i = 7; i >= 0; i--) begin
            fb  = crc[15] ^ data[i];
            crc = {crc[14:0], 1'b0};
            if (fb) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

    task automatic predict_command(input t_sumd_in item);
        logic [15:0] crc;
        logic [15:0] scaled;
        t_sumd_out   b;
        int          n;
        case (item.cmd)
            CMD_WRITE: begin
                if (item.channel_index < MAX_CH) begin
                    chan_vals[item.channel_index] = item.channel_value;
                end
            end
            CMD_UPDATE: begin
                n = int'(num_ch_reg);
                if (n < 1) n = 1;
                if (n > MAX_CH) n = MAX_CH;
                frame_buf[0] = HDR_BYTE;
                frame_buf[1] = item.failsafe ? STATUS_FAILSAFE : STATUS_OK;
                frame_buf[2] = n[7:0];
                for (int i = 0; i < n; i++) begin
                    scaled = chan_vals[i] << 3;
                    frame_buf[3 + 2 * i] = scaled[15:8];
                    frame_buf[4 + 2 * i] = scaled[7:0];
                end
                crc = CRC_INIT;
                for (int i = 0; i < 2 * n + 3; i++) begin
                    crc = crc16_step(crc, frame_buf[i]);
                end
                frame_buf[2 * n + 3] = crc[15:8];
                frame_buf[2 * n + 4] = crc[7:0];
                frame_len = 2 * n + 5;
                running   = 1'b1;
            end
            CMD_STOP: begin
                running = 1'b0;
            end
            default: begin
                // tick while stopped sends nothing
                if (running) begin
                    for (int i = 0; i < frame_len; i++) begin
                        b.frame_byte = frame_buf[i];
                        b.last_byte  = (i == frame_len - 1);
                        exp_bytes.push_back(b);
                    end
                end
            end
        endcase
    endtask

    task automatic check_frame_byte(input t_sumd_out got);
        t_sumd_out want;
        if (exp_bytes.size() == 0) begin
            $display("%0t: unexpected byte, expected none, actual byte %h last %b",
                     $time, got.frame_byte, got.last_byte);
            errors++;
        end else begin
            want = exp_bytes.pop_front();
            if (got.frame_byte !== want.frame_byte) begin
                $display("%0t: frame_byte mismatch, expected %h, actual %h",
                         $time, want.frame_byte, got.frame_byte);
                errors++;
            end
            if (got.last_byte !== want.last_byte) begin
                $display("%0t: last_byte mismatch, expected %b, actual %b",
                         $time, want.last_byte, got.last_byte);
                errors++;
            end
        end
    endtask

    // byte sink with its own stall pattern
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            check_frame_byte(out_data);
        end
        case (rx_mode)
            RX_FULL: begin
                out_ready <= 1'b1;
            end
            RX_RANDOM: begin
                if (ready_hold == 0) begin
                    out_ready  <= ~out_ready;
                    ready_hold <= out_ready ? $urandom_range(1, 6) : $urandom_range(1, 16);
                end else begin
                    ready_hold <= ready_hold - 1;
                end
            end
            default: begin
                out_ready <= (cycle_count % 5) > 1;
            end
        endcase
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // sender works in bursts; valid drops only when a burst ends
    task automatic send_item(input t_sumd_in item);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 10);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_command(item);
        burst_left--;
        if (burst_left == 0) begin
            in_valid <= 1'b0;
        end
    endtask

    task automatic hold_input();
        if (burst_left != 0) begin
            in_valid   <= 1'b0;
            burst_left = 0;
        end
    endtask

    // an update leaves no result behind, so let it finish before touching the register
    task automatic wait_drain();
        while (exp_bytes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_channel_count(input logic [4:0] count);
        hold_input();
        wait_drain();
        cfg_we    <= 1'b1;
        cfg_count <= count;
        @(posedge clk);
        cfg_we     <= 1'b0;
        num_ch_reg = count;
    endtask

    function automatic t_sumd_in make_item(input t_cmd c);
        t_sumd_in item;
        item.cmd           = c;
        item.channel_index = 4'($urandom_range(0, 15));
        item.failsafe      = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0: item.channel_value = 16'h0000;
            1: item.channel_value = 16'hFFFF;
            2: item.channel_value = 16'h1FFF;
            3: item.channel_value = 16'hE000;
            default: item.channel_value = 16'($urandom_range(0, 65535));
        endcase
        return item;
    endfunction

    function automatic t_sumd_in fixed_item(input t_cmd c, input logic [3:0] idx,
                                            input logic [15:0] val, input logic fs);
        t_sumd_in item;
        item.cmd           = c;
        item.channel_index = idx;
        item.channel_value = val;
        item.failsafe      = fs;
        return item;
    endfunction

    task automatic test_idle_commands();
        send_item(fixed_item(CMD_TICK, 4'd0, 16'h0000, 1'b0));
        send_item(fixed_item(CMD_STOP, 4'd15, 16'hFFFF, 1'b1));
        send_item(fixed_item(CMD_TICK, 4'd15, 16'hFFFF, 1'b1));
    endtask

    task automatic test_reset_frame();
        send_item(fixed_item(CMD_UPDATE, 4'd0, 16'h0000, 1'b0));
        send_item(fixed_item(CMD_TICK, 4'd0, 16'h0000, 1'b0));
    endtask

    task automatic test_channel_extremes();
        set_channel_count(5'd16);
        rx_mode = RX_RANDOM;
        send_item(fixed_item(CMD_WRITE, 4'd0, 16'hFFFF, 1'b0));
        send_item(fixed_item(CMD_WRITE, 4'd15, 16'hFFFF, 1'b0));
        // top three bits fall off the shift
        send_item(fixed_item(CMD_WRITE, 4'd1, 16'hE000, 1'b0));
        send_item(fixed_item(CMD_WRITE, 4'd2, 16'h1FFF, 1'b0));
        send_item(fixed_item(CMD_UPDATE, 4'd0, 16'h0000, 1'b1));
        send_item(fixed_item(CMD_TICK, 4'd0, 16'h0000, 1'b0));
        send_item(fixed_item(CMD_TICK, 4'd0, 16'h0000, 1'b1));
    endtask

    task automatic test_count_clamp();
        set_channel_count(5'd0);
        send_item(fixed_item(CMD_UPDATE, 4'd0, 16'h0000, 1'b0));
        send_item(fixed_item(CMD_TICK, 4'd0, 16'h0000, 1'b0));
        set_channel_count(5'd31);
        send_item(fixed_item(CMD_UPDATE, 4'd0, 16'h0000, 1'b1));
        send_item(fixed_item(CMD_TICK, 4'd0, 16'h0000, 1'b0));
        set_channel_count(5'd1);
        send_item(fixed_item(CMD_UPDATE, 4'd0, 16'h0000, 1'b0));
        send_item(fixed_item(CMD_TICK, 4'd0, 16'h0000, 1'b0));
    endtask

    task automatic test_latched_length();
        rx_mode = RX_PATTERN;
        set_channel_count(5'd3);
        send_item(fixed_item(CMD_UPDATE, 4'd0, 16'h0000, 1'b1));
        // length stays with the latched frame
        set_channel_count(5'd16);
        send_item(fixed_item(CMD_TICK, 4'd0, 16'h0000, 1'b0));
        send_item(fixed_item(CMD_STOP, 4'd0, 16'h0000, 1'b0));
        send_item(fixed_item(CMD_TICK, 4'd0, 16'h0000, 1'b0));
        send_item(fixed_item(CMD_UPDATE, 4'd0, 16'h0000, 1'b0));
        send_item(fixed_item(CMD_TICK, 4'd0, 16'h0000, 1'b0));
    endtask

    task automatic test_random_traffic();
        int made;
        made = 0;
        while (made < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 5))
                    0: set_channel_count(5'd0);
                    1: set_channel_count(5'd1);
                    2: set_channel_count(5'd16);
                    3: set_channel_count(5'($urandom_range(17, 31)));
                    default: set_channel_count(5'($urandom_range(1, 16)));
                endcase
            end
            rx_mode = 2'($urandom_range(0, 2));
            repeat ($urandom_range(0, 6)) begin
                send_item(make_item(CMD_WRITE));
                made++;
            end
            if ($urandom_range(0, 7) != 0) begin
                send_item(make_item(CMD_UPDATE));
                made++;
            end
            repeat ($urandom_range(1, 3)) begin
                send_item(make_item(CMD_TICK));
                made++;
            end
            if ($urandom_range(0, 5) == 0) begin
                send_item(make_item(CMD_STOP));
                send_item(make_item(CMD_TICK));
                made += 2;
            end
            if ($urandom_range(0, 4) == 0) begin
                send_item(make_item(t_cmd'($urandom_range(0, 3))));
                made++;
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_idle_commands();
        test_reset_frame();
        test_channel_extremes();
        test_count_clamp();
        test_latched_length();
        test_random_traffic();
        hold_input();
        wait_drain();
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### files.f
rtl/sumd_pkg.sv
rtl/sumd_chan_store.sv
rtl/sumd_frame_store.sv
rtl/sumd_frame_encoder.sv
sim/tb_sumd_frame_encoder.sv
